>>> src/r64d_pkg.sv
// ----------------------------------------------------------------------------
// r64d_pkg
// Shared types and constants for the radix-64 text to bytes decoder.
// ----------------------------------------------------------------------------
package r64d_pkg;

  localparam int unsigned CAP_W = 13;

  localparam logic [CAP_W-1:0] MAX_CAPACITY   = 13'd4096;
  localparam logic [CAP_W-1:0] CAPACITY_RESET = 13'd4096;

  localparam logic [7:0] CHAR_NUL  = 8'h00;
  localparam logic [7:0] CHAR_HASH = 8'h23;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_LAST = 8'h6f;   // '0' + 63
  localparam logic [7:0] CHAR_NINE = 8'h38;   // '8', the largest tail count
  localparam logic [3:0] DATA_BITS = 4'd6;

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END  = 1'b1;

  typedef enum logic [2:0] {
    PH_MAIN,
    PH_COUNT,
    PH_VALUE,
    PH_DONE,
    PH_FAIL
  } phase_t;

  typedef struct packed {
    logic       op;
    logic [7:0] char_code;
    logic [7:0] prior_byte;
  } item_t;

  typedef struct packed {
    logic       is_status;
    logic [7:0] data_byte;
    logic       success;
    logic       last;
  } result_t;

  typedef struct packed {
    phase_t           phase;
    logic [6:0]       acc;
    logic [2:0]       held;
    logic [3:0]       tail_width;
    logic [CAP_W-1:0] produced;
  } dec_state_t;

  // results of one step, up to two
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } step_out_t;

endpackage

>>> src/r64d_step.sv
// ----------------------------------------------------------------------------
// r64d_step
// Decode step for one registered item: next decoder state and its results.
// ----------------------------------------------------------------------------
module r64d_step (
  input  r64d_pkg::dec_state_t      st,
  input  r64d_pkg::item_t           item,
  input  logic [r64d_pkg::CAP_W-1:0] capacity,
  output r64d_pkg::dec_state_t      st_next,
  output r64d_pkg::step_out_t       res
);

  logic [r64d_pkg::CAP_W-1:0] cap;
  logic [7:0]  val;
  logic        is_data;
  logic        is_count;
  logic        tail_fits;
  logic [3:0]  add_count;
  logic [14:0] merged_bits;
  logic [4:0]  new_held;
  logic [4:0]  round_up;
  logic [r64d_pkg::CAP_W:0] need;
  logic        add_ok;
  logic        add_emit;
  logic        do_add;
  logic [7:0]  mask;
  logic        end_bad;
  logic        leftover;
  logic        end_room;
  r64d_pkg::phase_t phase_next;

  assign cap = (capacity > r64d_pkg::MAX_CAPACITY) ? r64d_pkg::MAX_CAPACITY : capacity;
  assign val = item.char_code - r64d_pkg::CHAR_ZERO;

  assign is_data  = (item.char_code >= r64d_pkg::CHAR_ZERO) &&
                    (item.char_code <= r64d_pkg::CHAR_LAST);
  assign is_count = (item.char_code >= r64d_pkg::CHAR_ZERO) &&
                    (item.char_code <= r64d_pkg::CHAR_NINE);
  assign tail_fits = (item.char_code >= r64d_pkg::CHAR_ZERO) &&
                     ((val >> st.tail_width) == 8'd0);

  assign add_count   = (st.phase == r64d_pkg::PH_VALUE) ? st.tail_width : r64d_pkg::DATA_BITS;
  assign merged_bits = {8'd0, st.acc} | ({7'd0, val} << st.held);
  assign new_held    = {2'd0, st.held} + {1'b0, add_count};
  assign round_up    = new_held + 5'd7;
  assign need        = {1'b0, st.produced} + {{(r64d_pkg::CAP_W-1){1'b0}}, round_up[4:3]};
  assign add_ok      = need <= {1'b0, cap};
  assign add_emit    = new_held[4:3] != 2'd0;

  // a character that adds bits and passes its own checks
  assign do_add = (item.op == r64d_pkg::OP_CHAR) &&
                  (((st.phase == r64d_pkg::PH_MAIN) && is_data) ||
                   ((st.phase == r64d_pkg::PH_VALUE) && tail_fits));

  assign mask     = (8'd1 << st.held) - 8'd1;
  assign end_bad  = (st.phase == r64d_pkg::PH_FAIL) || (st.phase == r64d_pkg::PH_COUNT) ||
                    (st.phase == r64d_pkg::PH_VALUE);
  assign leftover = st.held != 3'd0;
  assign end_room = st.produced < cap;

  // next phase
  always_comb begin
    phase_next = st.phase;
    if (item.op == r64d_pkg::OP_END) begin
      phase_next = r64d_pkg::PH_MAIN;
    end else begin
      unique case (st.phase) inside
        r64d_pkg::PH_MAIN: begin
          if (item.char_code == r64d_pkg::CHAR_NUL) begin
            phase_next = r64d_pkg::PH_DONE;
          end else if (item.char_code == r64d_pkg::CHAR_HASH) begin
            phase_next = r64d_pkg::PH_COUNT;
          end else if (!is_data || !add_ok) begin
            phase_next = r64d_pkg::PH_FAIL;
          end
        end
        r64d_pkg::PH_COUNT: begin
          if (!is_count) begin
            phase_next = r64d_pkg::PH_FAIL;
          end else if (val == 8'd0) begin
            phase_next = r64d_pkg::PH_DONE;
          end else begin
            phase_next = r64d_pkg::PH_VALUE;
          end
        end
        r64d_pkg::PH_VALUE: begin
          phase_next = (tail_fits && add_ok) ? r64d_pkg::PH_DONE : r64d_pkg::PH_FAIL;
        end
        r64d_pkg::PH_DONE, r64d_pkg::PH_FAIL: begin
          phase_next = st.phase;
        end
        default: begin
          phase_next = r64d_pkg::PH_FAIL;
        end
      endcase
    end
  end

  // datapath and results
  always_comb begin
    st_next.phase      = phase_next;
    st_next.acc        = st.acc;
    st_next.held       = st.held;
    st_next.tail_width = st.tail_width;
    st_next.produced   = st.produced;
    res                = '0;

    if (item.op == r64d_pkg::OP_END) begin
      st_next.acc        = '0;
      st_next.held       = '0;
      st_next.tail_width = '0;
      st_next.produced   = '0;
      if (!end_bad && leftover && end_room) begin
        res.count           = 2'd2;
        res.first.data_byte = (item.prior_byte & ~mask) | ({1'b0, st.acc} & mask);
        res.second.is_status = 1'b1;
        res.second.success   = 1'b1;
        res.second.last      = 1'b1;
      end else begin
        res.count           = 2'd1;
        res.first.is_status = 1'b1;
        res.first.success   = !end_bad && !leftover;
        res.first.last      = 1'b1;
      end
    end else begin
      if ((st.phase == r64d_pkg::PH_COUNT) && is_count) begin
        st_next.tail_width = val[3:0];
      end
      if (do_add && add_ok) begin
        if (add_emit) begin
          res.count           = 2'd1;
          res.first.data_byte = merged_bits[7:0];
          st_next.acc         = merged_bits[14:8];
          st_next.held        = new_held[2:0];
          st_next.produced    = st.produced + {{(r64d_pkg::CAP_W-1){1'b0}}, 1'b1};
        end else begin
          st_next.acc  = merged_bits[6:0];
          st_next.held = new_held[2:0];
        end
      end
    end
  end

endmodule

>>> src/r64d_outq.sv
// ----------------------------------------------------------------------------
// r64d_outq
// Four-entry result queue taking up to two results per cycle.
// ----------------------------------------------------------------------------
module r64d_outq (
  input  logic                 clk,
  input  logic                 rst,
  input  r64d_pkg::step_out_t  push,
  output logic                 room,
  output logic                 head_valid,
  output r64d_pkg::result_t    head,
  input  logic                 pop
);

  r64d_pkg::result_t entries [4];
  logic [1:0] wp;
  logic [1:0] rp;
  logic [2:0] count;
  logic [2:0] count_next;
  logic       do_pop;

  assign head_valid = count != 3'd0;
  assign head       = entries[rp];
  assign do_pop     = pop && head_valid;
  assign room       = count <= 3'd2;
  assign count_next = count + {1'b0, push.count} - {2'd0, do_pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + push.count;
      rp    <= rp + {1'b0, do_pop};
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wp] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wp + 2'd1] <= push.second;
    end
  end

endmodule

>>> src/radix64_text_to_bytes_decoder_unit.sv
// ----------------------------------------------------------------------------
// radix64_text_to_bytes_decoder_unit
// Radix-64 text decoder, lsb first, alphabet from '0', with '#' tail.
// ----------------------------------------------------------------------------
//  channel | direction | beat contents
//  in      | sink      | op, char_code, prior_byte
//  out     | source    | is_status, data_byte, success, last
//  cfg     | sink      | cfg_data (destination capacity)
//
//  one character per cycle while the queue has room: input register, one decode step, result queue
//  an input beat passes the input register and the result queue before its first result beat
//  an end beat gives one or two result beats, drained by the queue
//  the step stalls while the queue holds more than two results
//  rst is synchronous; it clears state and sets capacity to 4096
module radix64_text_to_bytes_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [7:0]  char_code,
  input  logic [7:0]  prior_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_status,
  output logic [7:0]  data_byte,
  output logic        success,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data
);

  logic [r64d_pkg::CAP_W-1:0] capacity;
  logic                 held_valid;
  r64d_pkg::item_t      held_item;
  r64d_pkg::dec_state_t st;
  r64d_pkg::dec_state_t st_next;
  r64d_pkg::step_out_t  step_res;
  r64d_pkg::step_out_t  push;
  r64d_pkg::result_t    head;
  logic                 room;
  logic                 fire;

  assign cfg_ready = 1'b1;
  assign fire      = held_valid && room;
  assign in_ready  = !held_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= r64d_pkg::CAPACITY_RESET;
    end else if (cfg_valid) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (fire) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= '{op: op, char_code: char_code, prior_byte: prior_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{phase: r64d_pkg::PH_MAIN, acc: '0, held: '0, tail_width: '0, produced: '0};
    end else if (fire) begin
      st <= st_next;
    end
  end

  r64d_step u_step (
    .st       (st),
    .item     (held_item),
    .capacity (capacity),
    .st_next  (st_next),
    .res      (step_res)
  );

  // nothing goes into the queue unless the step fires
  always_comb begin
    push = step_res;
    if (!fire) begin
      push.count = 2'd0;
    end
  end

  r64d_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (room),
    .head_valid (out_valid),
    .head       (head),
    .pop        (out_ready)
  );

  assign is_status = head.is_status;
  assign data_byte = head.data_byte;
  assign success   = head.success;
  assign last      = head.last;

endmodule

>>> src/r64d_checker.sv
// ----------------------------------------------------------------------------
// r64d_checker
// Port-level checks on the decoder's result beats, bound to the top level.
// ----------------------------------------------------------------------------
module r64d_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        is_status,
  input logic [7:0]  data_byte,
  input logic        success,
  input logic        last
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(is_status) && $stable(data_byte) &&
      $stable(success) && $stable(last))
    else $error("result beat changed while stalled");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_status |-> last && (data_byte == 8'd0))
    else $error("status beat not marked last or carries data");

  a_data_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_status |-> !success && !last)
    else $error("data beat carries status flags");

  // an empty output stays empty while no input handshake fires now or at its $past sample
  a_no_early_out: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !(in_valid && in_ready) && !$past(in_valid && in_ready) |=> !out_valid)
    else $error("result beat without a prior input beat");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat straight after reset");

endmodule

bind radix64_text_to_bytes_decoder_unit r64d_checker u_r64d_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .is_status (is_status),
  .data_byte (data_byte),
  .success   (success),
  .last      (last)
);
